FILE: hdl/cnc_pkg.sv
// ----------------------------------------------------------------------------
// cnc_pkg
// Shared types and constants of the cosine nearest-class classifier.
// ----------------------------------------------------------------------------
package cnc_pkg;

  localparam int ELEM_W     = 16;
  localparam int IN_ELEMS   = 8;
  localparam int CLASS_W    = 16;
  localparam int NORM_W     = 32;
  localparam int SCORE_W    = 16;
  localparam int FUNC_W     = 2;
  localparam int PROD_W     = 32;
  localparam int NORM_SHIFT = 28;
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = 36;
  localparam int SQRT_CNT_W = 5;
  localparam int DIV_STEPS  = 15;
  localparam int DIV_D_W    = 64;
  localparam int DIV_R_W    = 65;

  localparam logic [SCORE_W-1:0] SCORE_ONE = 16'h8000;

  localparam logic [FUNC_W-1:0] FUNC_LOAD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLASSIFY = 2'd2;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOMATCH = 2'd2,
    STAT_HIT     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_ISSUE,
    ST_SQ_WAIT,
    ST_SQRT_GO,
    ST_SQRT_RUN,
    ST_LOAD_WR,
    ST_WALK,
    ST_DRAIN,
    ST_REPLY
  } state_t;

  // Side information that travels with one reference through the score pipe.
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               elig;
    logic [CLASS_W-1:0] cls;
  } div_tag_t;

endpackage

FILE: hdl/cnc_ram.sv
// ----------------------------------------------------------------------------
// cnc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cnc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: hdl/cnc_dot.sv
// ----------------------------------------------------------------------------
// cnc_dot
// Lane multipliers and a summing stage: products registered, then the dot sum registered.
// ----------------------------------------------------------------------------
module cnc_dot
  import cnc_pkg::*;
#(
  parameter int VECTOR_LEN = 8,
  parameter int DOT_W      = 36
) (
  input  logic                           clk,
  input  logic [VECTOR_LEN*ELEM_W-1:0]   a_vec,
  input  logic [VECTOR_LEN*ELEM_W-1:0]   b_vec,
  output logic signed [DOT_W-1:0]        dot
);

  logic signed [PROD_W-1:0] prod_r [VECTOR_LEN];
  logic signed [DOT_W-1:0]  sum_nxt;

  always_ff @(posedge clk) begin
    for (int i = 0; i < VECTOR_LEN; i++) begin
      prod_r[i] <= $signed(a_vec[i*ELEM_W +: ELEM_W]) * $signed(b_vec[i*ELEM_W +: ELEM_W]);
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < VECTOR_LEN; i++) begin
      sum_nxt = sum_nxt + DOT_W'(prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    dot <= sum_nxt;
  end

endmodule

FILE: hdl/cnc_sqrt.sv
// ----------------------------------------------------------------------------
// cnc_sqrt
// Digit-by-digit integer square root of (sum << 28), one root bit per cycle.
// ----------------------------------------------------------------------------
module cnc_sqrt
  import cnc_pkg::*;
#(
  parameter int SUM_W = 35
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  sum,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic                  active_r;
  logic                  done_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0]      x_r;
  logic [REM_W-1:0]      rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  ge;

  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], x_r[RAD_W-1 -: 2]};
    trial  = REM_W'({root_r, 2'b01});
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
      end else if (active_r && (cnt_r == '0)) begin
        active_r <= 1'b0;
        done_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= RAD_W'(sum) << NORM_SHIFT;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '1;
    end else if (active_r) begin
      x_r    <= x_r << 2;
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

FILE: hdl/cnc_div.sv
// ----------------------------------------------------------------------------
// cnc_div
// Pipelined restoring divider: score = floor(dot * 2^43 / d), saturated.
// ----------------------------------------------------------------------------
module cnc_div
  import cnc_pkg::*;
#(
  parameter int DOT_W = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [DOT_W-2:0]     dot,
  input  logic [DIV_D_W-1:0]   d,
  input  div_tag_t             tag_in,
  output logic [SCORE_W-1:0]   score,
  output div_tag_t             tag_out
);

  logic [DIV_R_W-1:0]   r_r   [DIV_STEPS+1];
  logic [DIV_D_W-1:0]   d_r   [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_r   [DIV_STEPS+1];
  logic                 sat_r [DIV_STEPS+1];
  div_tag_t             tag_r [DIV_STEPS+1];
  logic [DIV_R_W-1:0]   r0;

  assign r0 = DIV_R_W'(dot) << NORM_SHIFT;

  always_ff @(posedge clk) begin
    r_r[0]   <= r0;
    d_r[0]   <= d;
    q_r[0]   <= '0;
    sat_r[0] <= (r0 >= DIV_R_W'(d));
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else begin
      tag_r[0] <= tag_in;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [DIV_R_W-1:0] sh;
    logic               ge;

    assign sh = r_r[k-1] << 1;
    assign ge = (sh >= DIV_R_W'(d_r[k-1]));

    always_ff @(posedge clk) begin
      r_r[k]   <= ge ? (sh - DIV_R_W'(d_r[k-1])) : sh;
      d_r[k]   <= d_r[k-1];
      q_r[k]   <= {q_r[k-1][DIV_STEPS-2:0], ge};
      sat_r[k] <= sat_r[k-1];
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign score   = sat_r[DIV_STEPS] ? SCORE_ONE : {1'b0, q_r[DIV_STEPS]};
  assign tag_out = tag_r[DIV_STEPS];

endmodule

FILE: hdl/cosine_nearest_class.sv
// ----------------------------------------------------------------------------
// cosine_nearest_class
// Nearest-class search by cosine similarity over a store of references.
// ----------------------------------------------------------------------------
// Flow: clear, unused codes and a dropped load go straight to the reply; a
// load runs the dot stage and the 32-step square root, then writes its row;
// a classify takes its norm the same way, then the walk reads one reference row a
// cycle from the vector and metadata RAMs, then the 16-stage divider drains.
// One item at a time: busy stays high from transfer to result strobe.
// Reset empties the store (count to zero) and idles; RAMs are not cleared.
// The receiver cannot stall: out_strobe marks each result for one cycle.
module cosine_nearest_class
  import cnc_pkg::*;
#(
  parameter int VECTOR_LEN = 8,
  parameter int REF_DEPTH  = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic [CLASS_W-1:0]        in_class_tag,
  input  logic signed [ELEM_W-1:0]  in_elem_0,
  input  logic signed [ELEM_W-1:0]  in_elem_1,
  input  logic signed [ELEM_W-1:0]  in_elem_2,
  input  logic signed [ELEM_W-1:0]  in_elem_3,
  input  logic signed [ELEM_W-1:0]  in_elem_4,
  input  logic signed [ELEM_W-1:0]  in_elem_5,
  input  logic signed [ELEM_W-1:0]  in_elem_6,
  input  logic signed [ELEM_W-1:0]  in_elem_7,
  output logic                      out_strobe,
  output logic [1:0]                out_status,
  output logic [CLASS_W-1:0]        out_best_class,
  output logic [SCORE_W-1:0]        out_best_score
);

  localparam int AW     = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CNT_W  = $clog2(REF_DEPTH + 1);
  localparam int VEC_W  = VECTOR_LEN * ELEM_W;
  localparam int META_W = CLASS_W + NORM_W;
  localparam int DOT_W  = PROD_W + $clog2(VECTOR_LEN) + 1;

  // Input vector, padded with zeros beyond the eight element ports.
  logic [ELEM_W-1:0] in_elem_a [IN_ELEMS];
  logic [VEC_W-1:0]  q_in;

  assign in_elem_a[0] = in_elem_0;
  assign in_elem_a[1] = in_elem_1;
  assign in_elem_a[2] = in_elem_2;
  assign in_elem_a[3] = in_elem_3;
  assign in_elem_a[4] = in_elem_4;
  assign in_elem_a[5] = in_elem_5;
  assign in_elem_a[6] = in_elem_6;
  assign in_elem_a[7] = in_elem_7;

  for (genvar i = 0; i < VECTOR_LEN; i++) begin : g_qin
    if (i < IN_ELEMS) begin : g_port
      assign q_in[i*ELEM_W +: ELEM_W] = in_elem_a[i];
    end else begin : g_zero
      assign q_in[i*ELEM_W +: ELEM_W] = '0;
    end
  end

  // Control and item registers.
  state_t               state_r, state_nxt;
  logic [FUNC_W-1:0]    func_r;
  logic [CLASS_W-1:0]   tag_r;
  logic [VEC_W-1:0]     q_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [AW-1:0]        n_r, n_nxt;
  logic [NORM_W-1:0]    nq_r, nq_nxt;
  logic [SCORE_W-1:0]   best_score_r, best_score_nxt;
  logic [CLASS_W-1:0]   best_cls_r, best_cls_nxt;
  status_t              rsp_status_r, rsp_status_nxt;

  // Walk pipeline alongside the RAM read and the dot stage.
  div_tag_t             s1_tag_r, s2_tag_r, s3_tag_r;
  logic [DIV_D_W-1:0]   s2_d_r, s3_d_r;

  logic                 issue_vld, issue_last;
  logic                 sq_sel;
  logic                 sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]    sqrt_root;
  logic                 ram_we;
  logic                 store_full;
  logic [VEC_W-1:0]     vec_rdata;
  logic [META_W-1:0]    meta_rdata;
  logic [NORM_W-1:0]    meta_norm;
  logic [CLASS_W-1:0]   meta_cls;
  logic [VEC_W-1:0]     dot_b;
  logic signed [DOT_W-1:0] dot;
  logic                 dot_pos;
  div_tag_t             div_tag_in, div_tag_out;
  logic [SCORE_W-1:0]   div_score;
  logic                 take_best;

  assign store_full = (count_r == CNT_W'(REF_DEPTH));
  assign meta_norm  = meta_rdata[NORM_W-1:0];
  assign meta_cls   = meta_rdata[META_W-1:NORM_W];

  // Reference store: one row of elements, one row of class and norm.
  cnc_ram #(.WIDTH(VEC_W), .DEPTH(REF_DEPTH)) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (q_r),
    .raddr (n_r),
    .rdata (vec_rdata)
  );

  cnc_ram #(.WIDTH(META_W), .DEPTH(REF_DEPTH)) u_meta_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({tag_r, nq_r}),
    .raddr (n_r),
    .rdata (meta_rdata)
  );

  // Dot unit squares the item itself for its norm, else takes the RAM row.
  assign dot_b = sq_sel ? q_r : vec_rdata;

  cnc_dot #(.VECTOR_LEN(VECTOR_LEN), .DOT_W(DOT_W)) u_dot (
    .clk   (clk),
    .a_vec (q_r),
    .b_vec (dot_b),
    .dot   (dot)
  );

  cnc_sqrt #(.SUM_W(DOT_W-1)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .sum   (dot[DOT_W-2:0]),
    .root  (sqrt_root),
    .done  (sqrt_done)
  );

  // A reference scores only with a nonzero norm and a positive dot product.
  assign dot_pos = !dot[DOT_W-1] && (dot != '0);

  always_comb begin
    div_tag_in      = s3_tag_r;
    div_tag_in.elig = s3_tag_r.elig && dot_pos;
  end

  cnc_div #(.DOT_W(DOT_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .dot     (dot[DOT_W-2:0]),
    .d       (s3_d_r),
    .tag_in  (div_tag_in),
    .score   (div_score),
    .tag_out (div_tag_out)
  );

  // Only a strictly greater score replaces the best; ties keep the earlier one.
  assign take_best = div_tag_out.vld && div_tag_out.elig && (div_score > best_score_r);

  // Walk pipeline: RAM data at s1, products and norm product at s2,
  // dot sum and aligned divisor at s3.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else begin
      s1_tag_r <= '{vld: issue_vld, last: issue_last, elig: 1'b0, cls: '0};
      s2_tag_r <= '{vld: s1_tag_r.vld, last: s1_tag_r.last,
                    elig: (meta_norm != '0), cls: meta_cls};
      s3_tag_r <= s2_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_d_r <= DIV_D_W'(nq_r) * DIV_D_W'(meta_norm);
    s3_d_r <= s2_d_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_func)
            FUNC_LOAD:     state_nxt = store_full ? ST_REPLY : ST_SQ_ISSUE;
            FUNC_CLASSIFY: state_nxt = ST_SQ_ISSUE;
            default:       state_nxt = ST_REPLY;
          endcase
        end
      end
      ST_SQ_ISSUE: state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT:  state_nxt = ST_SQRT_GO;
      ST_SQRT_GO:  state_nxt = ST_SQRT_RUN;
      ST_SQRT_RUN: begin
        if (sqrt_done) begin
          if (func_r == FUNC_LOAD) begin
            state_nxt = ST_LOAD_WR;
          end else if ((sqrt_root == '0) || (count_r == '0)) begin
            state_nxt = ST_REPLY;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_LOAD_WR: state_nxt = ST_REPLY;
      ST_WALK: begin
        if (issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (div_tag_out.vld && div_tag_out.last) begin
          state_nxt = ST_REPLY;
        end
      end
      ST_REPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    count_nxt      = count_r;
    n_nxt          = n_r;
    nq_nxt         = nq_r;
    best_score_nxt = best_score_r;
    best_cls_nxt   = best_cls_r;
    rsp_status_nxt = rsp_status_r;
    issue_vld      = 1'b0;
    issue_last     = 1'b0;
    sq_sel         = 1'b0;
    sqrt_start     = 1'b0;
    ram_we         = 1'b0;

    if (take_best) begin
      best_score_nxt = div_score;
      best_cls_nxt   = div_tag_out.cls;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          best_score_nxt = '0;
          best_cls_nxt   = '0;
          rsp_status_nxt = STAT_DONE;
          case (in_func)
            FUNC_LOAD: begin
              if (store_full) begin
                rsp_status_nxt = STAT_FULL;
              end
            end
            FUNC_CLEAR: count_nxt = '0;
            default:    ;
          endcase
        end
      end
      ST_SQ_ISSUE: sq_sel = 1'b1;
      ST_SQ_WAIT:  ;
      ST_SQRT_GO:  sqrt_start = 1'b1;
      ST_SQRT_RUN: begin
        if (sqrt_done) begin
          nq_nxt = sqrt_root;
          n_nxt  = '0;
          if ((func_r != FUNC_LOAD) && ((sqrt_root == '0) || (count_r == '0))) begin
            rsp_status_nxt = STAT_NOMATCH;
          end
        end
      end
      ST_LOAD_WR: begin
        ram_we    = 1'b1;
        count_nxt = count_r + 1'b1;
      end
      ST_WALK: begin
        issue_vld  = 1'b1;
        issue_last = ((CNT_W'(n_r) + 1'b1) == count_r);
        n_nxt      = n_r + 1'b1;
      end
      ST_DRAIN: begin
        if (div_tag_out.vld && div_tag_out.last) begin
          rsp_status_nxt = (best_score_nxt == '0) ? STAT_NOMATCH : STAT_HIT;
        end
      end
      ST_REPLY: ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rsp_status_r <= STAT_DONE;
      best_score_r <= '0;
      best_cls_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rsp_status_r <= rsp_status_nxt;
      best_score_r <= best_score_nxt;
      best_cls_r   <= best_cls_nxt;
    end
  end

  // Item payload: hold from transfer until the reply.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      func_r <= in_func;
      tag_r  <= in_class_tag;
      q_r    <= q_in;
    end
    n_r  <= n_nxt;
    nq_r <= nq_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = (state_r == ST_REPLY);
  assign out_status     = rsp_status_r;
  assign out_best_class = best_cls_r;
  assign out_best_score = best_score_r;

endmodule
